>>> src/lpg_pkg.sv
// Package for the line pixel generator: coordinate size, register indexes,
// and the command and status structs that join the controller to the datapath.
// Used by lpg_ctrl, lpg_datapath and line_pixel_generator.
package lpg_pkg;

  localparam int COORD_BITS = 6;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int VIS_BITS   = 7;
  localparam int STRIDE_BITS = 13;
  localparam int ADDR_BITS  = 32;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;
  localparam int S_DATA_BITS = 56;
  localparam int M_DATA_BITS = 64;

  localparam logic [CFG_INDEX_BITS-1:0] REG_VISIBLE_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VISIBLE_HEIGHT = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_STRIDE     = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_BASE     = 8'd3;

  typedef struct packed {
    logic load;
    logic emit;
  } lpg_cmd_t;

  typedef struct packed {
    logic at_end;
    logic out_valid;
  } lpg_sts_t;

endpackage

>>> src/line_pixel_generator.sv
// Top level of the line pixel generator: joins lpg_ctrl and lpg_datapath.
// Depends on lpg_pkg.
//
// One word on the slave side is a line command; the block then gives one
// word per point of the Bresenham line from start to end inclusive, which
// is max(|end_x - start_x|, |end_y - start_y|) + 1 words, at most 64. The
// walk register update produces one point per cycle while the master side
// takes words, after the command has been loaded into the walk registers.
// The next command is taken once the last point has left the walk registers;
// it may wait in the output register meanwhile. Clipped points still come
// out, with tuser low. Configuration writes are taken at any time and
// should be made only while no line is in progress.
module line_pixel_generator (
  input  logic                                clk,
  input  logic                                rst,
  // fields from bit 0 up: start_x, start_y, end_x, end_y, alpha, red, green, blue
  input  logic [lpg_pkg::S_DATA_BITS-1:0]     s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // fields from bit 0 up: byte_address, pixel_word
  output logic [lpg_pkg::M_DATA_BITS-1:0]     m_tdata,
  // fields from bit 0 up: write_enable
  output logic                                m_tuser,
  output logic                                m_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [lpg_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  lpg_pkg::lpg_cmd_t cmd;
  lpg_pkg::lpg_sts_t sts;

  assign cfg_ready = 1'b1;

  lpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

>>> src/lpg_ctrl.sv
// Controller for the line pixel generator: idle/run state machine.
// Issues load and emit commands to lpg_datapath; depends on lpg_pkg.
module lpg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              m_tready,
  input  lpg_pkg::lpg_sts_t sts,
  output lpg_pkg::lpg_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd.load = (state == ST_IDLE) && s_tvalid;
    cmd.emit = (state == ST_RUN) && (!sts.out_valid || m_tready);
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd.emit && sts.at_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/lpg_datapath.sv
// Datapath for the line pixel generator: configuration registers, Bresenham
// walk registers, address computation and the output word register.
// Driven by lpg_ctrl commands; depends on lpg_pkg.
module lpg_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lpg_pkg::lpg_cmd_t                    cmd,
  output lpg_pkg::lpg_sts_t                    sts,
  input  logic                                 cfg_valid,
  input  logic [lpg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [lpg_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic [lpg_pkg::S_DATA_BITS-1:0]      s_tdata,
  input  logic                                 m_tready,
  output logic                                 m_tvalid,
  output logic [lpg_pkg::M_DATA_BITS-1:0]      m_tdata,
  output logic                                 m_tuser,
  output logic                                 m_tlast
);

  localparam int CB = lpg_pkg::COORD_BITS;
  localparam int EB = lpg_pkg::ERR_BITS;
  localparam int VB = lpg_pkg::VIS_BITS;
  localparam int SB = lpg_pkg::STRIDE_BITS;
  localparam int AB = lpg_pkg::ADDR_BITS;
  localparam int PB = CB + SB;

  logic [VB-1:0] visible_width;
  logic [VB-1:0] visible_height;
  logic [SB-1:0] row_stride;
  logic [AB-1:0] frame_base;

  logic [CB-1:0] cur_x;
  logic [CB-1:0] cur_y;
  logic [CB-1:0] target_x;
  logic [CB-1:0] target_y;
  logic [CB-1:0] delta_x;
  logic [CB-1:0] delta_y;
  logic [1:0]    step_signs;
  logic [EB-1:0] error_term;
  logic [31:0]   color_word;
  logic [CB-1:0] point_count;

  logic [CB-1:0] in_sx;
  logic [CB-1:0] in_sy;
  logic [CB-1:0] in_ex;
  logic [CB-1:0] in_ey;
  logic [CB-1:0] in_dx;
  logic [CB-1:0] in_dy;

  logic          done;
  logic [EB:0]   e2;
  logic [EB:0]   dx_ext;
  logic [EB:0]   dy_ext;
  logic          step_x;
  logic          step_y;
  logic [EB-1:0] error_next;
  logic [PB-1:0] row_product;
  logic [AB-1:0] addr;
  logic          we;

  logic          out_valid;
  logic [AB-1:0] out_addr;
  logic [31:0]   out_pixel;
  logic          out_we;
  logic          out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      visible_width  <= VB'(64);
      visible_height <= VB'(64);
      row_stride     <= SB'(64);
      frame_base     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lpg_pkg::REG_VISIBLE_WIDTH:  visible_width  <= cfg_data[VB-1:0];
        lpg_pkg::REG_VISIBLE_HEIGHT: visible_height <= cfg_data[VB-1:0];
        lpg_pkg::REG_ROW_STRIDE:     row_stride     <= cfg_data[SB-1:0];
        lpg_pkg::REG_FRAME_BASE:     frame_base     <= cfg_data[AB-1:0];
        default: ;
      endcase
    end
  end

  assign in_sx = s_tdata[CB-1:0];
  assign in_sy = s_tdata[2*CB-1:CB];
  assign in_ex = s_tdata[3*CB-1:2*CB];
  assign in_ey = s_tdata[4*CB-1:3*CB];
  assign in_dx = (in_sx > in_ex) ? in_sx - in_ex : in_ex - in_sx;
  assign in_dy = (in_sy > in_ey) ? in_sy - in_ey : in_ey - in_sy;

  assign done   = (cur_x == target_x) && (cur_y == target_y);
  assign e2     = {error_term[EB-1], error_term} <<< 1;
  assign dx_ext = {{(EB+1-CB){1'b0}}, delta_x};
  assign dy_ext = {{(EB+1-CB){1'b0}}, delta_y};
  assign step_x = $signed(e2) > -$signed(dy_ext);
  assign step_y = $signed(e2) < $signed(dx_ext);

  always_comb begin
    error_next = error_term;
    if (step_x) begin
      error_next = error_next - dy_ext[EB-1:0];
    end
    if (step_y) begin
      error_next = error_next + dx_ext[EB-1:0];
    end
  end

  assign row_product = PB'(cur_y) * PB'(row_stride);
  assign addr = frame_base + {{(AB-PB-2){1'b0}}, row_product, 2'b00}
              + {{(AB-CB-2){1'b0}}, cur_x, 2'b00};
  assign we = ({1'b0, cur_x} < visible_width) && ({1'b0, cur_y} < visible_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      target_x    <= '0;
      target_y    <= '0;
      delta_x     <= '0;
      delta_y     <= '0;
      step_signs  <= '0;
      error_term  <= '0;
      color_word  <= '0;
      point_count <= '0;
    end else if (cmd.load) begin
      cur_x       <= in_sx;
      cur_y       <= in_sy;
      target_x    <= in_ex;
      target_y    <= in_ey;
      delta_x     <= in_dx;
      delta_y     <= in_dy;
      step_signs  <= {!(in_sy < in_ey), !(in_sx < in_ex)};
      error_term  <= {{(EB-CB){1'b0}}, in_dx} - {{(EB-CB){1'b0}}, in_dy};
      color_word  <= {s_tdata[4*CB+7:4*CB], s_tdata[4*CB+15:4*CB+8],
                      s_tdata[4*CB+23:4*CB+16], s_tdata[4*CB+31:4*CB+24]};
      point_count <= '0;
    end else if (cmd.emit) begin
      point_count <= point_count + CB'(1);
      error_term  <= error_next;
      if (step_x) begin
        cur_x <= step_signs[0] ? cur_x - CB'(1) : cur_x + CB'(1);
      end
      if (step_y) begin
        cur_y <= step_signs[1] ? cur_y - CB'(1) : cur_y + CB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_addr  <= addr;
      out_pixel <= color_word;
      out_we    <= we;
      out_last  <= done;
    end
  end

  assign sts.at_end    = done || (point_count == {CB{1'b1}});
  assign sts.out_valid = out_valid;

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_pixel, out_addr};
  assign m_tuser  = out_we;
  assign m_tlast  = out_last;

endmodule
